@@ src/bde_pkg.sv @@
// ----------------------------------------------------------------------------
// bde_pkg
// Shared operation codes, field widths and controller command type for the
// bounded deque engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bde_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 3;
    localparam int CAP_W  = 7;
    localparam int OCC_W  = 7;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
    localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic read;     // issue front and rear reads
        logic load;     // capture the result into the output register
    } t_ctrl;

endpackage

`default_nettype wire

@@ src/bde_ram.sv @@
// ----------------------------------------------------------------------------
// bde_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ src/bde_ctrl.sv @@
// ----------------------------------------------------------------------------
// bde_ctrl
// Controller: input/output handshake and the accept, read, load sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_ctrl (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output bde_pkg::t_ctrl o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // read data stays put until the output register frees up
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ src/bde_datapath.sv @@
// ----------------------------------------------------------------------------
// bde_datapath
// Ring pointers, capacity register, entry store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bde_pkg::t_ctrl                 i_cmd,
    input  wire logic                           i_cfg_we,
    input  wire logic [bde_pkg::CAP_W-1:0]      i_cfg_data,
    input  wire logic [bde_pkg::OP_W-1:0]       i_op,
    input  wire logic signed [bde_pkg::WORD_W-1:0] i_value,
    output logic                                o_ok,
    output logic signed [bde_pkg::WORD_W-1:0]   o_front_value,
    output logic signed [bde_pkg::WORD_W-1:0]   o_rear_value,
    output logic                                o_is_empty,
    output logic                                o_is_full,
    output logic      [bde_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CAPW = (CW > bde_pkg::CAP_W) ? CW : bde_pkg::CAP_W;

    logic [AW-1:0]                r_head;
    logic [AW-1:0]                n_head;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [bde_pkg::CAP_W-1:0]    r_cap;
    logic                         r_ok;
    logic                         n_ok;

    logic [CAPW-1:0]              cap_ext;
    logic [CAPW-1:0]              eff_cap;
    logic                         full;
    logic                         empty;
    logic [AW-1:0]                head_inc;
    logic [AW-1:0]                head_dec;
    logic [SW-1:0]                tail_sum;
    logic [AW-1:0]                tail_addr;
    logic [CW-1:0]                count_m1;
    logic [SW-1:0]                rear_sum;
    logic [AW-1:0]                rear_addr;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [bde_pkg::WORD_W-1:0]   rdata_front;
    logic [bde_pkg::WORD_W-1:0]   rdata_rear;

    // capacity saturated to 1..DEPTH
    always_comb begin
        cap_ext = CAPW'(r_cap);
        if (r_cap == '0) begin
            eff_cap = CAPW'(1);
        end else if (cap_ext > CAPW'(DEPTH)) begin
            eff_cap = CAPW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign full  = CAPW'(r_count) >= eff_cap;
    assign empty = (r_count == '0);

    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);

    // head + count wraps at most once
    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_count);
        if (tail_sum >= SW'(DEPTH)) begin
            tail_sum = tail_sum - SW'(DEPTH);
        end
        tail_addr = tail_sum[AW-1:0];

        count_m1 = empty ? '0 : r_count - CW'(1);
        rear_sum = SW'(r_head) + SW'(count_m1);
        if (rear_sum >= SW'(DEPTH)) begin
            rear_sum = rear_sum - SW'(DEPTH);
        end
        rear_addr = rear_sum[AW-1:0];
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_ok    = 1'b0;
        we      = 1'b0;
        waddr   = tail_addr;
        case (i_op)
            bde_pkg::OP_PUSH_FRONT: begin
                if (!full) begin
                    n_head  = head_dec;
                    waddr   = head_dec;
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            bde_pkg::OP_PUSH_REAR: begin
                if (!full) begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            bde_pkg::OP_POP_FRONT: begin
                if (!empty) begin
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            bde_pkg::OP_POP_REAR: begin
                if (!empty) begin
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            bde_pkg::OP_QUERY: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_cap   <= bde_pkg::CAP_RESET;
        end else begin
            if (i_cmd.accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ok <= n_ok;
        end
    end

    bde_ram #(
        .WIDTH (bde_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (i_cmd.accept && we),
        .i_waddr   (waddr),
        .i_wdata   (i_value),
        .i_re      (i_cmd.read),
        .i_raddr_a (r_head),
        .i_raddr_b (rear_addr),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_rear)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_ok          <= r_ok;
            o_front_value <= empty ? bde_pkg::EMPTY_WORD : rdata_front;
            o_rear_value  <= empty ? bde_pkg::EMPTY_WORD : rdata_rear;
            o_is_empty    <= empty;
            o_is_full     <= full;
            o_occupancy   <= bde_pkg::OCC_W'(r_count);
        end
    end

endmodule

`default_nettype wire

@@ src/bounded_deque_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed 32-bit words held in a ring.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one operation per
// transaction: push front, push rear, pop front, pop rear or query, with the
// word to push. Output channel (o_out_valid / i_out_stall) returns exactly one
// result per operation: success flag, front and rear words after the
// operation (all ones when empty), empty and full flags and the occupancy.
// A transaction is taken at a clock edge where valid is high and stall low.
// Each operation passes through accept with the ring update and store write,
// a read of the front and rear entries from the two-port store, and the
// load of the result register; the result is valid once loaded, and no new
// operation is taken until the previous one has been loaded.
// While a result is held under stall the next operation is still accepted;
// its result waits in the store read register until the output frees up.
// i_cfg_we writes the capacity register (saturated to 1..DEPTH) and must only
// be used while no operation is in flight.
// Synchronous reset empties the ring, clears the head pointer and sets the
// capacity to 64; stored words are not cleared and are never read unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bde_pkg::CAP_W-1:0]         i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [bde_pkg::OP_W-1:0]          i_op,
    input  wire logic signed [bde_pkg::WORD_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_ok,
    output logic signed [bde_pkg::WORD_W-1:0]      o_front_value,
    output logic signed [bde_pkg::WORD_W-1:0]      o_rear_value,
    output logic                                   o_is_empty,
    output logic                                   o_is_full,
    output logic      [bde_pkg::OCC_W-1:0]         o_occupancy
);

    bde_pkg::t_ctrl cmd;

    bde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    bde_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_ok          (o_ok),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_occupancy   (o_occupancy)
    );

endmodule

`default_nettype wire
